// ===== design/sffe_pkg.sv =====
// ----------------------------------------------------------------------------
// sffe_pkg
// Shared widths, reset values, register indexes and item types for the
// solenoid fringe field evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package sffe_pkg;

   localparam int POS_W    = 24;
   localparam int FIELD_W  = 30;
   localparam int CF_W     = 30;
   localparam int RSQ_W    = 40;
   localparam int LEN_W    = 23;
   localparam int XSQ_W    = 47;
   localparam int RR_W     = 48;
   localparam int ZLIM_W   = 25;
   localparam int T_W      = 26;
   localparam int Q_W      = 50;
   localparam int RATIO_W  = 32;
   localparam int S_W      = 62;
   localparam int ROOT_W   = 31;
   localparam int NORM_STEPS = 5;
   localparam int RATIO_LAT  = 2 + NORM_STEPS + ROOT_W + ROOT_W + 1;
   localparam int PADDR_W  = 5;
   localparam int PDATA_W  = 64;

   localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

   localparam logic [CF_W-1:0]  CENTER_FIELD_RST  = CF_W'(8000000);
   localparam logic [RSQ_W-1:0] RADIUS_SQ_RST     = RSQ_W'(900000000);
   localparam logic [LEN_W-1:0] COIL_LENGTH_RST   = LEN_W'(250000);
   localparam logic [LEN_W-1:0] FRINGE_LENGTH_RST = LEN_W'(50000);

   typedef enum logic [1:0] {
      REG_CENTER_FIELD,
      REG_RADIUS_SQ,
      REG_COIL_LENGTH,
      REG_FRINGE_LENGTH
   } reg_index_type;

   typedef struct packed {
      logic [CF_W-1:0]  center_field;
      logic [RSQ_W-1:0] radius_sq;
      logic [LEN_W-1:0] coil_length;
      logic [LEN_W-1:0] fringe_length;
   } cfg_type;

   typedef struct packed {
      logic                  in_region;
      logic signed [T_W-1:0] a2;
      logic signed [T_W-1:0] b2;
      logic [Q_W-1:0]        r4;
   } item_type;

endpackage

`default_nettype wire

// ===== design/solenoid_fringe_field_eval.sv =====
// ----------------------------------------------------------------------------
// solenoid_fringe_field_eval
// Axial field of a finite solenoid with fringe at one point per transfer.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_pos_x, req_pos_y, req_pos_z
//   rsp      out        rsp_valid/rsp_stall  rsp_field_z_ut, rsp_inside_region
//   csr      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// one point per cycle sustained while rsp is not stalled; latency is set by the
// square root and divide digit stages of the ratio pipelines and the final divide.
// a stall on rsp freezes the back end; the queue absorbs the front end until
// full, then req_stall rises. reset is synchronous and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module solenoid_fringe_field_eval #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [sffe_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [sffe_pkg::POS_W-1:0]    req_pos_y,
   input  logic signed [sffe_pkg::POS_W-1:0]    req_pos_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sffe_pkg::FIELD_W-1:0]         rsp_field_z_ut,
   output logic                                 rsp_inside_region,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sffe_pkg::PADDR_W-1:0]         paddr,
   input  logic [sffe_pkg::PDATA_W-1:0]         pwdata,
   output logic [sffe_pkg::PDATA_W-1:0]         prdata,
   output logic                                 pready
);

   localparam int PDATA_W = sffe_pkg::PDATA_W;
   localparam int PADDR_W = sffe_pkg::PADDR_W;

   sffe_pkg::cfg_type       cfg_ff;
   sffe_pkg::reg_index_type reg_index;
   logic                    wr_en;
   logic                    push;
   logic                    full;
   logic                    pop;
   logic                    empty;
   sffe_pkg::item_type      front_item;
   sffe_pkg::item_type      queue_item;

   always_comb begin
      pready    = 1'b1;
      wr_en     = psel && penable && pwrite && pready;
      reg_index = sffe_pkg::reg_index_type'(paddr[PADDR_W-1 -: 2]);
      case (reg_index)
         sffe_pkg::REG_CENTER_FIELD:  prdata = PDATA_W'(cfg_ff.center_field);
         sffe_pkg::REG_RADIUS_SQ:     prdata = PDATA_W'(cfg_ff.radius_sq);
         sffe_pkg::REG_COIL_LENGTH:   prdata = PDATA_W'(cfg_ff.coil_length);
         sffe_pkg::REG_FRINGE_LENGTH: prdata = PDATA_W'(cfg_ff.fringe_length);
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_field  <= sffe_pkg::CENTER_FIELD_RST;
         cfg_ff.radius_sq     <= sffe_pkg::RADIUS_SQ_RST;
         cfg_ff.coil_length   <= sffe_pkg::COIL_LENGTH_RST;
         cfg_ff.fringe_length <= sffe_pkg::FRINGE_LENGTH_RST;
      end else if (wr_en) begin
         case (reg_index)
            sffe_pkg::REG_CENTER_FIELD: begin
               cfg_ff.center_field <= pwdata[sffe_pkg::CF_W-1:0];
            end
            sffe_pkg::REG_RADIUS_SQ: begin
               cfg_ff.radius_sq <= pwdata[sffe_pkg::RSQ_W-1:0];
            end
            sffe_pkg::REG_COIL_LENGTH: begin
               cfg_ff.coil_length <= pwdata[sffe_pkg::LEN_W-1:0];
            end
            sffe_pkg::REG_FRINGE_LENGTH: begin
               cfg_ff.fringe_length <= pwdata[sffe_pkg::LEN_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   sffe_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pos_x (req_pos_x),
      .req_pos_y (req_pos_y),
      .req_pos_z (req_pos_z),
      .cfg       (cfg_ff),
      .full      (full),
      .push      (push),
      .item      (front_item)
   );

   sffe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (queue_item),
      .empty     (empty)
   );

   sffe_back u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (!empty),
      .item              (queue_item),
      .pop               (pop),
      .cfg               (cfg_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_field_z_ut    (rsp_field_z_ut),
      .rsp_inside_region (rsp_inside_region)
   );

endmodule

`default_nettype wire

// ===== design/sffe_ratio.sv =====
// ----------------------------------------------------------------------------
// sffe_ratio
// Pipelined Q2.30 ratio t/sqrt(t^2+q): square and sum, normalize, digit
// serial square root, then restoring divide, one stage per digit.
// ----------------------------------------------------------------------------
`default_nettype none

module sffe_ratio (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic signed [sffe_pkg::T_W-1:0]       t_in,
   input  logic [sffe_pkg::Q_W-1:0]              q_in,
   output logic signed [sffe_pkg::RATIO_W-1:0]   ratio_out
);

   localparam int T_W     = sffe_pkg::T_W;
   localparam int Q_W     = sffe_pkg::Q_W;
   localparam int S_W     = sffe_pkg::S_W;
   localparam int ROOT_W  = sffe_pkg::ROOT_W;
   localparam int NSTEP   = sffe_pkg::NORM_STEPS;
   localparam int RATIO_W = sffe_pkg::RATIO_W;

   typedef struct packed {
      logic [S_W-1:0]    s;
      logic [ROOT_W-1:0] mk;
      logic              neg;
      logic              zero;
   } norm_type;

   typedef struct packed {
      logic [S_W-1:0]    s;
      logic [ROOT_W+1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] mk;
      logic              neg;
      logic              zero;
   } sq_type;

   typedef struct packed {
      logic [ROOT_W-1:0] rem;
      logic [ROOT_W-1:0] root;
      logic [ROOT_W-1:0] quot;
      logic              neg;
      logic              zero;
   } dv_type;

   logic [T_W-1:0]   mag;
   logic [T_W-1:0]   m1_ff;
   logic [2*T_W-1:0] msq1_ff;
   logic [Q_W-1:0]   q1_ff;
   logic             neg1_ff;
   logic [S_W-1:0]   sum0;

   norm_type norm_in [0:NSTEP];
   norm_type norm_ff [0:NSTEP];
   sq_type   sq_head;
   sq_type   sq_in [0:ROOT_W-1];
   sq_type   sq_ff [0:ROOT_W-1];
   dv_type   dv_head;
   dv_type   dv_in [0:ROOT_W-1];
   dv_type   dv_ff [0:ROOT_W-1];

   logic [RATIO_W-1:0]        qx;
   logic signed [RATIO_W-1:0] ratio_in;
   logic signed [RATIO_W-1:0] ratio_ff;

   always_comb begin
      mag = t_in[T_W-1] ? T_W'(-t_in) : T_W'(t_in);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         m1_ff   <= mag;
         msq1_ff <= mag * mag;
         q1_ff   <= q_in;
         neg1_ff <= t_in[T_W-1];
      end
   end

   always_comb begin
      sum0             = S_W'(msq1_ff) + S_W'(q1_ff);
      norm_in[0].s     = sum0;
      norm_in[0].mk    = ROOT_W'(m1_ff);
      norm_in[0].neg   = neg1_ff;
      norm_in[0].zero  = (sum0 == '0);
   end

   // normalize by even shifts until the top bit pair is nonzero
   for (genvar j = 0; j < NSTEP; j++) begin : g_norm
      localparam int SH = 1 << (NSTEP - 1 - j);
      always_comb begin
         norm_in[j+1] = norm_ff[j];
         if (norm_ff[j].s[S_W-1 -: 2*SH] == '0) begin
            norm_in[j+1].s  = norm_ff[j].s << (2*SH);
            norm_in[j+1].mk = norm_ff[j].mk << SH;
         end
      end
   end

   always_comb begin
      sq_head.s    = norm_ff[NSTEP].s;
      sq_head.rem  = '0;
      sq_head.root = '0;
      sq_head.mk   = norm_ff[NSTEP].mk;
      sq_head.neg  = norm_ff[NSTEP].neg;
      sq_head.zero = norm_ff[NSTEP].zero;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
      sq_type            src;
      logic [ROOT_W+3:0] rsh;
      logic [ROOT_W+3:0] trial;
      if (i == 0) begin : g_first
         assign src = sq_head;
      end else begin : g_next
         assign src = sq_ff[i-1];
      end
      always_comb begin
         sq_in[i]   = src;
         rsh        = {src.rem, src.s[S_W-1 -: 2]};
         trial      = {2'b00, src.root, 2'b01};
         sq_in[i].s = {src.s[S_W-3:0], 2'b00};
         if (rsh >= trial) begin
            sq_in[i].rem  = (ROOT_W+2)'(rsh - trial);
            sq_in[i].root = {src.root[ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[i].rem  = rsh[ROOT_W+1:0];
            sq_in[i].root = {src.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      dv_head.rem  = sq_ff[ROOT_W-1].mk;
      dv_head.root = sq_ff[ROOT_W-1].root;
      dv_head.quot = '0;
      dv_head.neg  = sq_ff[ROOT_W-1].neg;
      dv_head.zero = sq_ff[ROOT_W-1].zero;
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_div
      dv_type          src;
      logic [ROOT_W:0] cand;
      if (i == 0) begin : g_first
         assign src = dv_head;
      end else begin : g_next
         assign src = dv_ff[i-1];
      end
      always_comb begin
         dv_in[i] = src;
         if (i == 0) begin
            cand = {1'b0, src.rem};
         end else begin
            cand = {src.rem, 1'b0};
         end
         if (cand >= {1'b0, src.root}) begin
            dv_in[i].rem  = ROOT_W'(cand - {1'b0, src.root});
            dv_in[i].quot = {src.quot[ROOT_W-2:0], 1'b1};
         end else begin
            dv_in[i].rem  = cand[ROOT_W-1:0];
            dv_in[i].quot = {src.quot[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      qx = RATIO_W'(dv_ff[ROOT_W-1].quot);
      if (dv_ff[ROOT_W-1].zero) begin
         ratio_in = '0;
      end else if (dv_ff[ROOT_W-1].neg) begin
         ratio_in = $signed(-qx);
      end else begin
         ratio_in = $signed(qx);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int n = 0; n <= NSTEP; n++) begin
            norm_ff[n] <= norm_in[n];
         end
         for (int n = 0; n < ROOT_W; n++) begin
            sq_ff[n] <= sq_in[n];
            dv_ff[n] <= dv_in[n];
         end
         ratio_ff <= ratio_in;
      end
   end

   assign ratio_out = ratio_ff;

endmodule

`default_nettype wire

// ===== design/sffe_front.sv =====
// ----------------------------------------------------------------------------
// sffe_front
// Input stage: takes a point, squares x and y, classifies it against the
// field region and forms the half-micrometre terms for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sffe_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sffe_pkg::POS_W-1:0]   req_pos_x,
   input  logic signed [sffe_pkg::POS_W-1:0]   req_pos_y,
   input  logic signed [sffe_pkg::POS_W-1:0]   req_pos_z,
   input  sffe_pkg::cfg_type                   cfg,
   input  logic                                full,
   output logic                                push,
   output sffe_pkg::item_type                  item
);

   localparam int POS_W  = sffe_pkg::POS_W;
   localparam int XSQ_W  = sffe_pkg::XSQ_W;
   localparam int RR_W   = sffe_pkg::RR_W;
   localparam int ZLIM_W = sffe_pkg::ZLIM_W;
   localparam int T_W    = sffe_pkg::T_W;
   localparam int Q_W    = sffe_pkg::Q_W;

   logic                     accept;
   logic                     valid_in;
   logic                     valid_ff;
   logic signed [2*POS_W-1:0] px;
   logic signed [2*POS_W-1:0] py;
   logic [XSQ_W-1:0]         xsq_ff;
   logic [XSQ_W-1:0]         ysq_ff;
   logic signed [POS_W-1:0]  z_ff;
   logic [RR_W-1:0]          rsq;
   logic signed [ZLIM_W-1:0] zx;
   logic [ZLIM_W-1:0]        az;
   logic [ZLIM_W-1:0]        zlim;
   logic signed [T_W-1:0]    z2;
   logic signed [T_W-1:0]    h2;

   always_comb begin
      req_stall = valid_ff && full;
      accept    = req_valid && !req_stall;
      push      = valid_ff && !full;
      valid_in  = accept ? 1'b1 : (push ? 1'b0 : valid_ff);
      px        = req_pos_x * req_pos_x;
      py        = req_pos_y * req_pos_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         xsq_ff <= px[XSQ_W-1:0];
         ysq_ff <= py[XSQ_W-1:0];
         z_ff   <= req_pos_z;
      end
   end

   always_comb begin
      rsq  = RR_W'(xsq_ff) + RR_W'(ysq_ff);
      zx   = ZLIM_W'(z_ff);
      az   = zx[ZLIM_W-1] ? ZLIM_W'(-zx) : ZLIM_W'(zx);
      zlim = {1'b0, cfg.coil_length, 1'b0} + ZLIM_W'(cfg.fringe_length);
      z2   = {z_ff[POS_W-1], z_ff, 1'b0};
      h2   = $signed(T_W'(cfg.coil_length));
      item.in_region = (az < zlim) && (rsq < RR_W'(cfg.radius_sq));
      item.a2        = z2 + h2;
      item.b2        = h2 - z2;
      item.r4        = Q_W'({rsq, 2'b00});
   end

endmodule

`default_nettype wire

// ===== design/sffe_queue.sv =====
// ----------------------------------------------------------------------------
// sffe_queue
// Short FIFO between the front and back ends so each side can stall alone.
// ----------------------------------------------------------------------------
`default_nettype none

module sffe_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sffe_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output sffe_pkg::item_type pop_item,
   output logic               empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sffe_pkg::item_type entries_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   always_comb begin
      full      = (count_ff == CNT_W'(DEPTH));
      empty     = (count_ff == '0);
      pop_item  = entries_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== design/sffe_back.sv =====
// ----------------------------------------------------------------------------
// sffe_back
// Back end: three ratio pipelines, scale by the central field, pipelined
// rounding divide, saturation, zeroing outside the region and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sffe_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               item_valid,
   input  sffe_pkg::item_type                 item,
   output logic                               pop,
   input  sffe_pkg::cfg_type                  cfg,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sffe_pkg::FIELD_W-1:0]       rsp_field_z_ut,
   output logic                               rsp_inside_region
);

   localparam int LAT     = sffe_pkg::RATIO_LAT;
   localparam int RATIO_W = sffe_pkg::RATIO_W;
   localparam int FIELD_W = sffe_pkg::FIELD_W;
   localparam int CF_W    = sffe_pkg::CF_W;
   localparam int T_W     = sffe_pkg::T_W;
   localparam int Q_W     = sffe_pkg::Q_W;
   localparam int N_W     = CF_W + RATIO_W;

   typedef struct packed {
      logic               in_region;
      logic               sat;
      logic               dz;
      logic [RATIO_W-1:0] rem;
      logic [RATIO_W-1:0] d;
      logic [FIELD_W-1:0] low;
      logic [FIELD_W-1:0] quot;
   } bd_type;

   logic                      adv;
   logic signed [T_W-1:0]     h_t;
   logic [Q_W-1:0]            h_q;
   logic signed [RATIO_W-1:0] ra_out;
   logic signed [RATIO_W-1:0] rb_out;
   logic signed [RATIO_W-1:0] rh_out;
   logic [LAT-1:0]            vl_ff;
   logic [LAT-1:0]            il_ff;

   logic signed [RATIO_W:0]   ssum;
   logic [RATIO_W-1:0]        f1_sum_ff;
   logic [RATIO_W-2:0]        f1_rh_ff;
   logic                      f1_inside_ff;
   logic                      f1_valid_ff;
   logic [N_W-1:0]            f2_prod_ff;
   logic [RATIO_W-2:0]        f2_rh_ff;
   logic                      f2_inside_ff;
   logic                      f2_valid_ff;
   logic [N_W-1:0]            f3_n_ff;
   logic [RATIO_W-1:0]        f3_d_ff;
   logic                      f3_inside_ff;
   logic                      f3_valid_ff;

   bd_type             bd_head;
   bd_type             bd_in [1:FIELD_W];
   bd_type             bd_ff [0:FIELD_W];
   logic [FIELD_W:0]   bv_ff;
   logic               out_valid_ff;
   logic [FIELD_W-1:0] field_in;
   logic [FIELD_W-1:0] field_ff;
   logic               inside_ff;

   always_comb begin
      adv = !out_valid_ff || !rsp_stall;
      pop = adv && item_valid;
      h_t = $signed(T_W'(cfg.coil_length));
      h_q = Q_W'({cfg.radius_sq, 2'b00});
   end

   sffe_ratio u_ratio_a (
      .clock     (clock),
      .enable    (adv),
      .t_in      (item.a2),
      .q_in      (item.r4),
      .ratio_out (ra_out)
   );

   sffe_ratio u_ratio_b (
      .clock     (clock),
      .enable    (adv),
      .t_in      (item.b2),
      .q_in      (item.r4),
      .ratio_out (rb_out)
   );

   sffe_ratio u_ratio_h (
      .clock     (clock),
      .enable    (adv),
      .t_in      (h_t),
      .q_in      (h_q),
      .ratio_out (rh_out)
   );

   always_comb begin
      ssum = (RATIO_W+1)'(ra_out) + (RATIO_W+1)'(rb_out);
   end

   always_comb begin
      bd_head.in_region = f3_inside_ff;
      bd_head.d         = f3_d_ff;
      bd_head.rem       = f3_n_ff[N_W-1 -: RATIO_W];
      bd_head.low       = f3_n_ff[FIELD_W-1:0];
      bd_head.quot      = '0;
      bd_head.sat       = (f3_n_ff[N_W-1 -: RATIO_W] >= f3_d_ff);
      bd_head.dz        = (f3_d_ff == '0);
   end

   for (genvar i = 1; i <= FIELD_W; i++) begin : g_div
      logic [RATIO_W:0] cand;
      always_comb begin
         bd_in[i]     = bd_ff[i-1];
         cand         = {bd_ff[i-1].rem, bd_ff[i-1].low[FIELD_W-1]};
         bd_in[i].low = {bd_ff[i-1].low[FIELD_W-2:0], 1'b0};
         if (cand >= {1'b0, bd_ff[i-1].d}) begin
            bd_in[i].rem  = RATIO_W'(cand - {1'b0, bd_ff[i-1].d});
            bd_in[i].quot = {bd_ff[i-1].quot[FIELD_W-2:0], 1'b1};
         end else begin
            bd_in[i].rem  = cand[RATIO_W-1:0];
            bd_in[i].quot = {bd_ff[i-1].quot[FIELD_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (!bd_ff[FIELD_W].in_region || bd_ff[FIELD_W].dz) begin
         field_in = '0;
      end else if (bd_ff[FIELD_W].sat) begin
         field_in = sffe_pkg::FIELD_MAX;
      end else begin
         field_in = bd_ff[FIELD_W].quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff        <= '0;
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         bv_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         vl_ff        <= {vl_ff[LAT-2:0], item_valid};
         f1_valid_ff  <= vl_ff[LAT-1];
         f2_valid_ff  <= f1_valid_ff;
         f3_valid_ff  <= f2_valid_ff;
         bv_ff        <= {bv_ff[FIELD_W-1:0], f3_valid_ff};
         out_valid_ff <= bv_ff[FIELD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         il_ff        <= {il_ff[LAT-2:0], item.in_region};
         f1_sum_ff    <= ssum[RATIO_W] ? '0 : ssum[RATIO_W-1:0];
         f1_rh_ff     <= rh_out[RATIO_W-2:0];
         f1_inside_ff <= il_ff[LAT-1];
         f2_prod_ff   <= f1_sum_ff * cfg.center_field;
         f2_rh_ff     <= f1_rh_ff;
         f2_inside_ff <= f1_inside_ff;
         f3_n_ff      <= f2_prod_ff + N_W'(f2_rh_ff);
         f3_d_ff      <= {f2_rh_ff, 1'b0};
         f3_inside_ff <= f2_inside_ff;
         bd_ff[0]     <= bd_head;
         for (int n = 1; n <= FIELD_W; n++) begin
            bd_ff[n] <= bd_in[n];
         end
         field_ff  <= field_in;
         inside_ff <= bd_ff[FIELD_W].in_region;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_field_z_ut    = field_ff;
   assign rsp_inside_region = inside_ff;

endmodule

`default_nettype wire
